// ===== rtl/shower_timer_cold_shot_alert_top_macros.svh =====
// Assertion macros for the shower timer top level.
`ifndef SHOWER_TIMER_COLD_SHOT_ALERT_TOP_MACROS_SVH
`define SHOWER_TIMER_COLD_SHOT_ALERT_TOP_MACROS_SVH

`ifndef SYNTH
`define STCSA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define STCSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define STCSA_ASSERT_IMPLIES(label, ante, cons)
`define STCSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/stcsa_pkg.sv =====
// Register map, reset values and bus widths of the shower timer.
`default_nettype none

package stcsa_pkg;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_TIMER_ENABLE  = 3'd0,
    REG_ALERT_ENABLE  = 3'd1,
    REG_ALERT_TRIGGER = 3'd2,
    REG_COLD_SHOT     = 3'd3,
    REG_MIN_DURATION  = 3'd4,
    REG_PAUSE         = 3'd5,
    REG_OFFSET        = 3'd6
  } reg_idx_t;

  localparam logic [15:0] ALERT_TRIGGER_RESET = 16'd420;
  localparam logic [15:0] COLD_SHOT_RESET     = 16'd10;
  localparam logic [15:0] MIN_DURATION_RESET  = 16'd180;
  localparam logic [7:0]  PAUSE_RESET         = 8'd15;
  localparam logic [7:0]  OFFSET_RESET        = 8'd5;

  localparam int IN_BYTES_BITS  = 8;
  localparam int OUT_BYTES_BITS = 40;

endpackage

`default_nettype wire

// ===== rtl/shower_timer_cold_shot_alert_top.sv =====
// An accepted item passes the input register, then the result register. Throughput: one item
// per cycle unless m_tready stalls; the state update is a single pass of subtracts and compares.
// The result register frees when its item is taken, so a new item enters during a stall drain.
// Reset (rst, synchronous, active high) clears the seconds clock, all timestamps and flags,
// and returns the configuration registers to their default values.
`default_nettype none

module shower_timer_cold_shot_alert_top #(
  parameter int TIME_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  // APB configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [stcsa_pkg::ADDR_BITS-1:0]    paddr,
  input  wire  [stcsa_pkg::DATA_BITS-1:0]    pwdata,
  output logic [stcsa_pkg::DATA_BITS-1:0]    prdata,
  output logic                               pready,
  // Input items
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // s_tdata: [0] tap_active, [1] coldshot_request, [7:2] zero
  input  wire  [stcsa_pkg::IN_BYTES_BITS-1:0] s_tdata,
  // Result items
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // m_tdata: [0] shower_on, [1] active_changed, [2] tap_off_request,
  // [3] tap_on_request, [4] duration_valid, [36:5] duration_seconds,
  // [37] coldshot_rejected, [39:38] zero
  output logic [stcsa_pkg::OUT_BYTES_BITS-1:0] m_tdata
);

  import stcsa_pkg::*;

  `include "shower_timer_cold_shot_alert_top_macros.svh"

  // Configuration registers
  logic        timer_enable;
  logic        alert_enable;
  logic [15:0] alert_trigger_seconds;
  logic [15:0] cold_shot_seconds;
  logic [15:0] min_duration_seconds;
  logic [7:0]  pause_seconds;
  logic [7:0]  offset_seconds;

  // Timer state
  logic [TIME_BITS-1:0] seconds_now, seconds_now_next;
  logic [TIME_BITS-1:0] flow_start_time, flow_start_time_next;
  logic [TIME_BITS-1:0] pause_start_time, pause_start_time_next;
  logic [TIME_BITS-1:0] alert_start_time, alert_start_time_next;
  logic [TIME_BITS-1:0] next_alert_mark, next_alert_mark_next;
  logic flow_running, flow_running_next;
  logic pause_running, pause_running_next;
  logic showering, showering_next;
  logic cold_shot_on, cold_shot_on_next;
  logic forced_pending, forced_pending_next;
  logic last_reported_active, last_reported_active_next;

  // Input register
  logic in_valid;
  logic in_tap;
  logic in_req;

  // Result register
  logic        res_valid;
  logic        res_active, res_changed, res_off, res_on, res_dvalid, res_rej;
  logic [31:0] res_dur;
  logic        changed_next, off_next, on_next, dvalid_next, rej_next;
  logic [31:0] dur_next;

  logic advance;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  // The computing stage moves when the result register is empty or being emptied.
  assign advance  = in_valid & (~res_valid | m_tready);
  assign s_tready = ~in_valid | advance;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_enable          <= 1'b0;
      alert_enable          <= 1'b0;
      alert_trigger_seconds <= ALERT_TRIGGER_RESET;
      cold_shot_seconds     <= COLD_SHOT_RESET;
      min_duration_seconds  <= MIN_DURATION_RESET;
      pause_seconds         <= PAUSE_RESET;
      offset_seconds        <= OFFSET_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_TIMER_ENABLE:  timer_enable          <= pwdata[0];
        REG_ALERT_ENABLE:  alert_enable          <= pwdata[0];
        REG_ALERT_TRIGGER: alert_trigger_seconds <= pwdata[15:0];
        REG_COLD_SHOT:     cold_shot_seconds     <= pwdata[15:0];
        REG_MIN_DURATION:  min_duration_seconds  <= pwdata[15:0];
        REG_PAUSE:         pause_seconds         <= pwdata[7:0];
        REG_OFFSET:        offset_seconds        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_TIMER_ENABLE:  prdata = {31'd0, timer_enable};
      REG_ALERT_ENABLE:  prdata = {31'd0, alert_enable};
      REG_ALERT_TRIGGER: prdata = {16'd0, alert_trigger_seconds};
      REG_COLD_SHOT:     prdata = {16'd0, cold_shot_seconds};
      REG_MIN_DURATION:  prdata = {16'd0, min_duration_seconds};
      REG_PAUSE:         prdata = {24'd0, pause_seconds};
      REG_OFFSET:        prdata = {24'd0, offset_seconds};
      default:           prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tap <= s_tdata[0];
      in_req <= s_tdata[1];
    end
  end

  // ---------------- one tick of the timer ----------------
  always_comb begin
    logic [TIME_BITS-1:0] flow_el;
    logic [TIME_BITS-1:0] pause_el;
    logic [TIME_BITS-1:0] cold_el;
    logic [TIME_BITS-1:0] dur_raw;
    logic [TIME_BITS-1:0] dur_net;
    logic [63:0]          dur_wide;
    logic                 set_call;

    seconds_now_next          = seconds_now + TIME_BITS'(1);
    flow_start_time_next      = flow_start_time;
    pause_start_time_next     = pause_start_time;
    alert_start_time_next     = alert_start_time;
    next_alert_mark_next      = next_alert_mark;
    flow_running_next         = flow_running;
    pause_running_next        = pause_running;
    showering_next            = showering;
    cold_shot_on_next         = cold_shot_on;
    forced_pending_next       = forced_pending;
    last_reported_active_next = last_reported_active;
    changed_next = 1'b0;
    off_next     = 1'b0;
    on_next      = 1'b0;
    dvalid_next  = 1'b0;
    rej_next     = 1'b0;
    dur_next     = '0;
    set_call     = 1'b0;

    flow_el  = seconds_now_next - flow_start_time;
    cold_el  = seconds_now_next - alert_start_time;
    pause_el = '0;
    dur_raw  = '0;
    dur_net  = '0;
    dur_wide = '0;

    if (timer_enable) begin
      // A request is settled before the flow logic sees forced_pending.
      if (in_req) begin
        if (showering) begin
          forced_pending_next = 1'b1;
        end else begin
          forced_pending_next = 1'b0;
          rej_next            = 1'b1;
        end
      end

      if (!cold_shot_on) begin
        if (in_tap) begin
          if (!flow_running) begin
            flow_running_next     = 1'b1;
            flow_start_time_next  = seconds_now_next;
            pause_running_next    = 1'b0;
            pause_start_time_next = '0;
            showering_next        = 1'b0;
            next_alert_mark_next  = TIME_BITS'(alert_trigger_seconds);
          end else if (!showering && flow_el > TIME_BITS'(min_duration_seconds)) begin
            showering_next = 1'b1;
            set_call       = 1'b1;
          end else if ((alert_enable && flow_el > next_alert_mark) || forced_pending_next) begin
            cold_shot_on_next     = 1'b1;
            forced_pending_next   = 1'b0;
            alert_start_time_next = seconds_now_next;
            off_next              = 1'b1;
          end
        end else begin
          if (flow_running && !pause_running) begin
            pause_running_next    = 1'b1;
            pause_start_time_next = seconds_now_next;
          end
          pause_el = seconds_now_next - pause_start_time_next;
          if (pause_running_next && pause_el > TIME_BITS'(pause_seconds)) begin
            dur_raw  = pause_start_time_next - flow_start_time;
            dur_net  = dur_raw - TIME_BITS'(offset_seconds);
            dur_wide = 64'(dur_net);
            if (dur_raw > TIME_BITS'(offset_seconds) &&
                dur_net > TIME_BITS'(min_duration_seconds)) begin
              dvalid_next = 1'b1;
              dur_next    = (dur_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : dur_wide[31:0];
            end
            flow_running_next     = 1'b0;
            flow_start_time_next  = '0;
            pause_running_next    = 1'b0;
            pause_start_time_next = '0;
            cold_shot_on_next     = 1'b0;
            alert_start_time_next = '0;
            showering_next        = 1'b0;
            set_call              = 1'b1;
          end
        end
      end else if (cold_el > TIME_BITS'(cold_shot_seconds)) begin
        cold_shot_on_next    = 1'b0;
        forced_pending_next  = 1'b0;
        next_alert_mark_next = next_alert_mark + TIME_BITS'(alert_trigger_seconds);
        on_next              = 1'b1;
      end

      if (set_call && (showering_next != last_reported_active)) begin
        last_reported_active_next = showering_next;
        changed_next              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now          <= '0;
      flow_start_time      <= '0;
      pause_start_time     <= '0;
      alert_start_time     <= '0;
      next_alert_mark      <= '0;
      flow_running         <= 1'b0;
      pause_running        <= 1'b0;
      showering            <= 1'b0;
      cold_shot_on         <= 1'b0;
      forced_pending       <= 1'b0;
      last_reported_active <= 1'b0;
    end else if (advance) begin
      seconds_now          <= seconds_now_next;
      flow_start_time      <= flow_start_time_next;
      pause_start_time     <= pause_start_time_next;
      alert_start_time     <= alert_start_time_next;
      next_alert_mark      <= next_alert_mark_next;
      flow_running         <= flow_running_next;
      pause_running        <= pause_running_next;
      showering            <= showering_next;
      cold_shot_on         <= cold_shot_on_next;
      forced_pending       <= forced_pending_next;
      last_reported_active <= last_reported_active_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_active  <= showering_next;
      res_changed <= changed_next;
      res_off     <= off_next;
      res_on      <= on_next;
      res_dvalid  <= dvalid_next;
      res_dur     <= dur_next;
      res_rej     <= rej_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {2'b00, res_rej, res_dur, res_dvalid, res_on, res_off,
                     res_changed, res_active};

  // ---------------- checks ----------------
  `STCSA_ASSERT_IMPLIES(a_off_on_exclusive, res_valid, !(res_off && res_on))
  `STCSA_ASSERT_IMPLIES(a_cold_shot_needs_flow, cold_shot_on, flow_running)
  `STCSA_ASSERT_IMPLIES(a_pause_needs_flow, pause_running, flow_running)
  `STCSA_ASSERT_NEXT(a_clock_ticks, advance,
                     seconds_now == $past(seconds_now) + TIME_BITS'(1))

endmodule

`default_nettype wire
